/* sv/mtd_pkg.sv */
// morse timing decoder: shared sizes, register indexes and helpers
// no dependencies; used by the channel interfaces, the core and its checker
package mtd_pkg;

  // pattern storage depth and run length width
  localparam int MAX_ELEMENTS   = 8;
  localparam int DURATION_WIDTH = 16;

  // fixed field widths of the registers and the result
  localparam int DASH_W     = 15;
  localparam int GAP_W      = 16;
  localparam int PAT_BITS_W = 8;
  localparam int PAT_LEN_W  = 4;

  // internal widths that follow from the depth, the run length width and the gap width
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W = ((DURATION_WIDTH > GAP_W) ? DURATION_WIDTH : GAP_W) + 1;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = GAP_W;

  localparam logic [CFG_INDEX_W-1:0] REG_DASH_THRESHOLD     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAR_GAP_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_GAP_THRESHOLD = 2'd2;

  typedef logic [MAX_ELEMENTS-1:0] elem_bits_t;
  typedef logic [CNT_W-1:0]        elem_cnt_t;
  typedef logic signed [CMP_W-1:0] cmp_t;

  // low result bits of the pattern register, zero filled when the depth is small
  function automatic logic [PAT_BITS_W-1:0] pat_bits_of(input elem_bits_t bits);
    logic [MAX_ELEMENTS+PAT_BITS_W-1:0] wide;
    wide = {{PAT_BITS_W{1'b0}}, bits};
    return wide[PAT_BITS_W-1:0];
  endfunction

  function automatic logic [PAT_LEN_W-1:0] pat_len_of(input elem_cnt_t cnt);
    logic [CNT_W+PAT_LEN_W-1:0] wide;
    wide = {{PAT_LEN_W{1'b0}}, cnt};
    return wide[PAT_LEN_W-1:0];
  endfunction

endpackage

/* sv/mtd_stream_if.sv */
// morse timing decoder: valid/ready channels for run lengths and symbols
// depends on mtd_pkg
interface mtd_run_if import mtd_pkg::*; ();
  logic                             valid;
  logic                             ready;
  logic signed [DURATION_WIDTH-1:0] duration;

  modport source (output valid, output duration, input ready);
  modport sink   (input valid, input duration, output ready);
  modport mon    (input valid, input duration, input ready);
endinterface

interface mtd_sym_if import mtd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  has_symbol;
  logic [PAT_BITS_W-1:0] pattern_bits;
  logic [PAT_LEN_W-1:0]  pattern_length;
  logic                  pattern_overflow;
  logic                  word_space;

  modport source (output valid, output has_symbol, output pattern_bits,
                  output pattern_length, output pattern_overflow,
                  output word_space, input ready);
  modport sink   (input valid, input has_symbol, input pattern_bits,
                  input pattern_length, input pattern_overflow,
                  input word_space, output ready);
  modport mon    (input valid, input has_symbol, input pattern_bits,
                  input pattern_length, input pattern_overflow,
                  input word_space, input ready);
endinterface

/* sv/morse_timing_decoder_core.sv */
// morse timing decoder core: run lengths in, dot/dash patterns and word spaces out
// depends on mtd_pkg and the channel interfaces in mtd_stream_if.sv
//
//   channel  dir  transfer when         payload
//   run      in   valid & ready         duration (signed run length)
//   sym      out  valid & ready         has_symbol, pattern_bits, pattern_length,
//                                       pattern_overflow, word_space
//   cfg      in   cfg_we                cfg_index, cfg_data
//
// a run transfer loads the input register; the decode then moves into the result
// register once it is free, raising sym valid if the run emits; sustained rate is
// one item per cycle unless sym stalls; the result register sets the pace
// run.ready drops only while the result register is full and sym is stalled
// rst (synchronous, active high) clears the pattern, the thresholds and both valids
module morse_timing_decoder_core import mtd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mtd_run_if.sink                run,
  mtd_sym_if.source              sym
);

  // configuration registers
  logic [DASH_W-1:0]       dash_threshold;
  logic signed [GAP_W-1:0] char_gap_threshold;
  logic signed [GAP_W-1:0] word_gap_threshold;

  // pattern under construction
  elem_bits_t element_bits, element_bits_next;
  elem_cnt_t  element_count, element_count_next;
  logic       element_overflow, element_overflow_next;
  logic       last_was_mark, last_was_mark_next;

  // input register
  logic                             stage_valid;
  logic signed [DURATION_WIDTH-1:0] stage_duration;

  // result register
  logic                  res_valid;
  logic                  res_has_symbol;
  logic [PAT_BITS_W-1:0] res_pattern_bits;
  logic [PAT_LEN_W-1:0]  res_pattern_length;
  logic                  res_pattern_overflow;
  logic                  res_word_space;

  // decode terms
  logic advance;
  logic out_free;
  cmp_t dur_ext, dash_ext, char_ext, word_ext;
  logic is_zero, is_mark;
  logic take;
  logic enabled;
  logic add_elem, set_dash;
  logic char_end, space, emit;

  // the stage moves on whenever the result register can take a result
  assign out_free  = !res_valid || sym.ready;
  assign advance   = stage_valid && out_free;
  assign run.ready = !stage_valid || out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dash_threshold     <= '0;
      char_gap_threshold <= '0;
      word_gap_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DASH_THRESHOLD:     dash_threshold     <= cfg_data[DASH_W-1:0];
        REG_CHAR_GAP_THRESHOLD: char_gap_threshold <= cfg_data[GAP_W-1:0];
        REG_WORD_GAP_THRESHOLD: word_gap_threshold <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (run.ready) begin
      stage_valid <= run.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run.valid && run.ready) begin
      stage_duration <= run.duration;
    end
  end

  // all threshold compares at a common signed width
  assign dur_ext  = cmp_t'(stage_duration);
  assign dash_ext = cmp_t'({1'b0, dash_threshold});
  assign char_ext = cmp_t'(char_gap_threshold);
  assign word_ext = cmp_t'(word_gap_threshold);

  assign is_zero = (stage_duration == '0);
  assign is_mark = !is_zero && !stage_duration[DURATION_WIDTH-1];

  // a flush counts only right after a mark
  assign take    = !is_zero || last_was_mark;
  assign enabled = take && (dash_threshold != '0);

  assign add_elem = enabled && is_mark && (element_count < CNT_W'(MAX_ELEMENTS));
  assign set_dash = add_elem && (dur_ext >= dash_ext);

  assign char_end = (dur_ext < char_ext) || is_zero;
  assign space    = dur_ext < word_ext;
  assign emit     = enabled && !is_mark && char_end && ((element_count != '0) || space);

  always_comb begin
    last_was_mark_next    = take ? is_mark : last_was_mark;
    element_bits_next     = element_bits;
    element_count_next    = element_count;
    element_overflow_next = element_overflow;
    if (emit) begin
      element_bits_next     = '0;
      element_count_next    = '0;
      element_overflow_next = 1'b0;
    end else if (add_elem) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        if (set_dash && (element_count == CNT_W'(i))) begin
          element_bits_next[i] = 1'b1;
        end
      end
      element_count_next = element_count + CNT_W'(1);
    end else if (enabled && is_mark) begin
      // pattern full: element dropped
      element_overflow_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_bits     <= '0;
      element_count    <= '0;
      element_overflow <= 1'b0;
      last_was_mark    <= 1'b0;
    end else if (advance) begin
      element_bits     <= element_bits_next;
      element_count    <= element_count_next;
      element_overflow <= element_overflow_next;
      last_was_mark    <= last_was_mark_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_has_symbol       <= (element_count != '0);
      res_pattern_bits     <= (element_count != '0) ? pat_bits_of(element_bits) : '0;
      res_pattern_length   <= pat_len_of(element_count);
      res_pattern_overflow <= (element_count != '0) && element_overflow;
      res_word_space       <= space;
    end
  end

  assign sym.valid            = res_valid;
  assign sym.has_symbol       = res_has_symbol;
  assign sym.pattern_bits     = res_pattern_bits;
  assign sym.pattern_length   = res_pattern_length;
  assign sym.pattern_overflow = res_pattern_overflow;
  assign sym.word_space       = res_word_space;

endmodule

/* sv/mtd_checker.sv */
// morse timing decoder: port-level checks on the symbol channel
// depends on mtd_pkg and mtd_sym_if; bound to morse_timing_decoder_core
module mtd_checker import mtd_pkg::*; (
  input logic       clk,
  input logic       rst,
  mtd_sym_if.source sym
);

  // nothing comes out in the cycle after reset
  assert property (@(posedge clk) rst |=> !sym.valid)
    else $error("sym valid right after reset");

  // a result without a symbol is a bare word space with an empty pattern
  assert property (@(posedge clk) disable iff (rst)
    (sym.valid && !sym.has_symbol) |->
      (sym.word_space && sym.pattern_bits == '0 && sym.pattern_length == '0
       && !sym.pattern_overflow))
    else $error("empty result carries pattern data or no word space");

  // a delivered symbol holds between one and the maximum number of elements
  assert property (@(posedge clk) disable iff (rst)
    (sym.valid && sym.has_symbol) |->
      (sym.pattern_length != '0 && sym.pattern_length <= PAT_LEN_W'(MAX_ELEMENTS)))
    else $error("symbol length out of range");

  // overflow is only reported on a full pattern
  assert property (@(posedge clk) disable iff (rst)
    (sym.valid && sym.pattern_overflow) |->
      (sym.pattern_length == PAT_LEN_W'(MAX_ELEMENTS)))
    else $error("overflow on a pattern that is not full");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (sym.valid && !sym.ready) |=>
      (sym.valid && $stable(sym.has_symbol) && $stable(sym.pattern_bits)
       && $stable(sym.pattern_length) && $stable(sym.pattern_overflow)
       && $stable(sym.word_space)))
    else $error("stalled result changed");

endmodule

bind morse_timing_decoder_core mtd_checker u_mtd_checker (
  .clk (clk),
  .rst (rst),
  .sym (sym)
);
